// ===== sv/mrbr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the multi-reader broadcast ring.
// Used by mrbr_ctrl, mrbr_dp and multi_reader_broadcast_ring; no dependencies.
package mrbr_pkg;

	localparam int ENTRY_SLOTS = 16;
	localparam int POS_W       = 4;
	localparam int CNT_W       = 5;
	localparam int SUB_SLOTS   = 32;
	localparam int SLOT_W      = 5;
	localparam int SLIM_W      = 6;
	localparam int PAY_W       = 64;
	localparam int LEN_W       = 4;
	localparam int ID_W        = 16;
	localparam int STAMP_W     = 32;
	localparam int READS_W     = 6;
	localparam int SIZE_W      = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_W       = 32;
	localparam int IN_DATA_W   = 120;
	localparam int OUT_DATA_W  = 80;

	typedef enum logic [1:0] {
		OP_PUBLISH,
		OP_READ,
		OP_SUBSCRIBE,
		OP_UNSUBSCRIBE
	} op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_LEN,
		ST_NO_DATA,
		ST_ALREADY,
		ST_NOT_SUB,
		ST_FULL
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RING_DEPTH,
		REG_SIZE_LIMIT,
		REG_SUB_LIMIT,
		REG_AGE_LIMIT,
		REG_READS_CONSUME
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOKUP,
		S_DISPATCH,
		S_EXPIRE,
		S_PUB,
		S_SCAN,
		S_HIT,
		S_SWEEP,
		S_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic    load;
		logic    lk_step;
		logic    exp_step;
		logic    pub_write;
		logic    scan_init;
		logic    scan_step;
		logic    hit;
		logic    sweep_step;
		logic    sub_write;
		logic    unsub;
		logic    res_set;
		status_t res_code;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		op_t              op;
		logic             lk_last;
		logic             lk_hit;
		logic             free_hit;
		logic             bad_len;
		logic             exp_go;
		logic             scan_end;
		logic             scan_hit;
		logic             hit_sweep;
		logic             sweep_go;
		logic             out_free;
		logic [CNT_W-1:0] fill;
		logic [CNT_W-1:0] depth;
	} stat_t;

	function automatic logic [PAY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [PAY_W-1:0] m;
		m = '0;
		for (int b = 0; b < PAY_W / 8; b++) begin
			m[b*8 +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p,
			input logic [CNT_W-1:0] depth);
		logic [CNT_W-1:0] p1;
		p1 = {1'b0, p} + CNT_W'(1);
		return (p1 >= depth) ? '0 : p1[POS_W-1:0];
	endfunction

endpackage

// ===== sv/mrbr_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the broadcast ring: walks lookup, expiry, scan and sweep.
// Depends on mrbr_pkg; drives mrbr_dp through cmd_t and reads stat_t.
module mrbr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  mrbr_pkg::stat_t st,
	output mrbr_pkg::cmd_t  cmd
);
	import mrbr_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				if (st.lk_last) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (st.op)
					OP_PUBLISH: state_d = st.bad_len ? S_EMIT : S_EXPIRE;
					OP_READ:    state_d = st.lk_hit ? S_EXPIRE : S_EMIT;
					default:    state_d = S_EMIT;
				endcase
			end
			S_EXPIRE: begin
				if (!st.exp_go) state_d = (st.op == OP_PUBLISH) ? S_PUB : S_SCAN;
			end
			S_PUB: state_d = S_EMIT;
			S_SCAN: begin
				if (st.scan_end) state_d = S_EMIT;
				else if (st.scan_hit) state_d = S_HIT;
			end
			S_HIT: state_d = st.hit_sweep ? S_SWEEP : S_EMIT;
			S_SWEEP: begin
				if (!st.sweep_go) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_code = ST_OK;
		s_tready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: cmd.load = s_tvalid;
			S_LOOKUP: cmd.lk_step = 1'b1;
			S_DISPATCH: begin
				cmd.res_set = 1'b1;
				case (st.op)
					OP_PUBLISH: cmd.res_code = st.bad_len ? ST_BAD_LEN : ST_OK;
					OP_READ:    cmd.res_code = st.lk_hit ? ST_OK : ST_NOT_SUB;
					OP_SUBSCRIBE: begin
						if (st.lk_hit) begin
							cmd.res_code = ST_ALREADY;
						end else if (st.free_hit) begin
							cmd.sub_write = 1'b1;
							cmd.res_code  = ST_OK;
						end else begin
							cmd.res_code = ST_FULL;
						end
					end
					default: begin
						cmd.unsub    = st.lk_hit;
						cmd.res_code = st.lk_hit ? ST_OK : ST_NOT_SUB;
					end
				endcase
			end
			S_EXPIRE: begin
				cmd.exp_step  = st.exp_go;
				cmd.scan_init = !st.exp_go;
			end
			S_PUB: cmd.pub_write = 1'b1;
			S_SCAN: begin
				if (st.scan_end) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_NO_DATA;
				end else if (!st.scan_hit) begin
					cmd.scan_step = 1'b1;
				end
			end
			S_HIT: cmd.hit = 1'b1;
			S_SWEEP: cmd.sweep_step = st.sweep_go;
			S_EMIT: cmd.emit = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== sv/mrbr_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the broadcast ring: entry store, subscriber table, config
// registers and output register. Depends on mrbr_pkg; steered by mrbr_ctrl.
module mrbr_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mrbr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mrbr_pkg::CFG_W-1:0]         cfg_data,
	input  logic [mrbr_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mrbr_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [2:0]                         m_tuser,
	input  mrbr_pkg::cmd_t                     cmd,
	output mrbr_pkg::stat_t                    st
);
	import mrbr_pkg::*;

	// configuration
	logic [CNT_W-1:0]   depth_q;
	logic [SIZE_W-1:0]  esl_q;
	logic [SLIM_W-1:0]  slim_q;
	logic [STAMP_W-1:0] age_q;
	logic [READS_W-1:0] rtc_q;

	// latched request
	op_t                op_q;
	logic [ID_W-1:0]    who_q;
	logic [STAMP_W-1:0] now_q;
	logic [PAY_W-1:0]   data_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   lim_q;

	// ring
	logic [PAY_W-1:0]    payload_q [ENTRY_SLOTS];
	logic [LEN_W-1:0]    length_q  [ENTRY_SLOTS];
	logic [STAMP_W-1:0]  stamp_q   [ENTRY_SLOTS];
	logic [READS_W-1:0]  reads_q   [ENTRY_SLOTS];
	logic [SUB_SLOTS-1:0] mask_q   [ENTRY_SLOTS];
	logic [ENTRY_SLOTS-1:0] valid_q;
	logic [POS_W-1:0]    wpos_q;
	logic [POS_W-1:0]    opos_q;
	logic [CNT_W-1:0]    fill_q;

	// subscribers
	logic [ID_W-1:0]      ident_q [SUB_SLOTS];
	logic [SUB_SLOTS-1:0] active_q;

	// walk counters
	logic [SLOT_W-1:0] lk_idx_q;
	logic              lk_hit_q;
	logic [SLOT_W-1:0] lk_slot_q;
	logic              free_hit_q;
	logic [SLOT_W-1:0] free_slot_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  cnt_q;

	// result and output
	status_t          res_status_q;
	logic [PAY_W-1:0] res_pay_q;
	logic [LEN_W-1:0] res_elen_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [PAY_W-1:0] out_pay_q;
	logic [LEN_W-1:0] out_elen_q;
	logic [CNT_W-1:0] out_occ_q;

	logic [STAMP_W-1:0] age_now;
	logic [READS_W-1:0] reads_new;
	logic               consume;
	logic               evict;
	logic [LEN_W-1:0]   rd_len;
	logic [SUB_SLOTS-1:0] sub_bit;
	logic [SLIM_W-1:0]  lk_next;

	always_comb begin
		age_now   = now_q - stamp_q[opos_q];
		reads_new = (reads_q[pos_q] == '1) ? reads_q[pos_q] : reads_q[pos_q] + READS_W'(1);
		consume   = (rtc_q != '0) && (reads_new >= rtc_q);
		evict     = (fill_q >= depth_q);
		rd_len    = (length_q[pos_q] < lim_q) ? length_q[pos_q] : lim_q;
		sub_bit   = SUB_SLOTS'(1) << lk_slot_q;
		lk_next   = {1'b0, lk_idx_q} + SLIM_W'(1);

		st.op        = op_q;
		st.lk_last   = (lk_next == slim_q);
		st.lk_hit    = lk_hit_q;
		st.free_hit  = free_hit_q;
		st.bad_len   = (len_q == '0) || (len_q > esl_q);
		st.exp_go    = (age_q != '0) && (fill_q != '0) && valid_q[opos_q] &&
			(age_now >= age_q);
		st.scan_end  = (cnt_q >= fill_q);
		st.scan_hit  = valid_q[pos_q] && ((mask_q[pos_q] & sub_bit) == '0);
		st.hit_sweep = consume && (pos_q == opos_q);
		st.sweep_go  = (fill_q != '0) && !valid_q[opos_q];
		st.out_free  = !out_valid_q || m_tready;
		st.fill      = fill_q;
		st.depth     = depth_q;
	end

	// control state: config, ring bookkeeping, subscriber table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= CNT_W'(ENTRY_SLOTS);
			esl_q    <= SIZE_W'(PAY_W / 8);
			slim_q   <= SLIM_W'(SUB_SLOTS);
			age_q    <= '0;
			rtc_q    <= '0;
			valid_q  <= '0;
			wpos_q   <= '0;
			opos_q   <= '0;
			fill_q   <= '0;
			active_q <= '0;
			for (int i = 0; i < ENTRY_SLOTS; i++) begin
				reads_q[i] <= '0;
				mask_q[i]  <= '0;
			end
			for (int i = 0; i < SUB_SLOTS; i++) begin
				ident_q[i] <= '0;
			end
		end else begin
			if (cmd.exp_step || cmd.sweep_step) begin
				if (cmd.exp_step) valid_q[opos_q] <= 1'b0;
				opos_q <= next_pos(opos_q, depth_q);
				fill_q <= fill_q - CNT_W'(1);
			end
			if (cmd.pub_write) begin
				if (evict) begin
					opos_q <= next_pos(opos_q, depth_q);
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
				// drop the evicted tail, then mark the new entry; they may share a slot
				valid_q <= (valid_q & ~(evict ? (ENTRY_SLOTS'(1) << opos_q) : '0)) |
					(ENTRY_SLOTS'(1) << wpos_q);
				reads_q[wpos_q] <= '0;
				mask_q[wpos_q]  <= '0;
				wpos_q <= next_pos(wpos_q, depth_q);
			end
			if (cmd.hit) begin
				mask_q[pos_q]  <= mask_q[pos_q] | sub_bit;
				reads_q[pos_q] <= reads_new;
				if (consume) valid_q[pos_q] <= 1'b0;
			end
			if (cmd.sub_write) begin
				ident_q[free_slot_q]  <= who_q;
				active_q[free_slot_q] <= 1'b1;
			end
			if (cmd.unsub) active_q[lk_slot_q] <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_RING_DEPTH: begin
						if (cfg_data[4:0] == '0) depth_q <= CNT_W'(1);
						else if (cfg_data[4:0] > CNT_W'(ENTRY_SLOTS))
							depth_q <= CNT_W'(ENTRY_SLOTS);
						else depth_q <= cfg_data[4:0];
						valid_q <= '0;
						wpos_q  <= '0;
						opos_q  <= '0;
						fill_q  <= '0;
						for (int i = 0; i < ENTRY_SLOTS; i++) begin
							reads_q[i] <= '0;
							mask_q[i]  <= '0;
						end
					end
					REG_SIZE_LIMIT: begin
						if (cfg_data[3:0] == '0) esl_q <= SIZE_W'(1);
						else if (cfg_data[3:0] > SIZE_W'(PAY_W / 8))
							esl_q <= SIZE_W'(PAY_W / 8);
						else esl_q <= cfg_data[3:0];
					end
					REG_SUB_LIMIT: begin
						if (cfg_data[5:0] == '0) slim_q <= SLIM_W'(1);
						else if (cfg_data[5:0] > SLIM_W'(SUB_SLOTS))
							slim_q <= SLIM_W'(SUB_SLOTS);
						else slim_q <= cfg_data[5:0];
					end
					REG_AGE_LIMIT: age_q <= cfg_data;
					REG_READS_CONSUME: rtc_q <= cfg_data[5:0];
					default: ;
				endcase
			end
		end
	end

	// payload storage and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= op_t'(s_tuser);
			who_q       <= s_tdata[15:0];
			now_q       <= s_tdata[47:16];
			data_q      <= s_tdata[111:48];
			len_q       <= s_tdata[115:112];
			lim_q       <= s_tdata[119:116];
			lk_idx_q    <= '0;
			lk_hit_q    <= 1'b0;
			free_hit_q  <= 1'b0;
			res_pay_q   <= '0;
			res_elen_q  <= '0;
		end
		if (cmd.lk_step) begin
			if (!lk_hit_q && active_q[lk_idx_q] && (ident_q[lk_idx_q] == who_q)) begin
				lk_hit_q  <= 1'b1;
				lk_slot_q <= lk_idx_q;
			end
			if (!free_hit_q && !active_q[lk_idx_q]) begin
				free_hit_q  <= 1'b1;
				free_slot_q <= lk_idx_q;
			end
			lk_idx_q <= lk_idx_q + SLOT_W'(1);
		end
		if (cmd.pub_write) begin
			payload_q[wpos_q] <= data_q & byte_mask(len_q);
			length_q[wpos_q]  <= len_q;
			stamp_q[wpos_q]   <= now_q;
		end
		if (cmd.scan_init) begin
			pos_q <= opos_q;
			cnt_q <= '0;
		end
		if (cmd.scan_step) begin
			pos_q <= next_pos(pos_q, depth_q);
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.res_set) res_status_q <= cmd.res_code;
		if (cmd.hit) begin
			res_status_q <= ST_OK;
			res_pay_q    <= payload_q[pos_q] & byte_mask(rd_len);
			res_elen_q   <= length_q[pos_q];
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_pay_q    <= res_pay_q;
			out_elen_q   <= res_elen_q;
			out_occ_q    <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'd0, out_occ_q, out_elen_q, out_pay_q};

endmodule

// ===== sv/multi_reader_broadcast_ring.sv =====
`timescale 1ns / 1ps
// Multi-reader broadcast ring: a message ring shared by a subscriber table.
// Use: one request per s_* transaction (s_tuser = opcode), one response per
// request on m_* (m_tuser = status). Configuration goes through cfg_we,
// cfg_index and cfg_data while no request is in flight; writing ring depth
// empties the ring.
// Timing: a request is taken only while the sequencer is idle. It walks the
// subscriber lookup (one slot per cycle, over subscriber_limit slots), a
// dispatch step, then for publish/read an expiry step per expired entry, for
// publish a write step, for read a scan step per ring entry scanned, a hit
// step and, if the hit consumes the tail entry, a sweep step per entry swept,
// then it loads the output register. The lookup scan over the subscriber
// table dominates.
// Reset: the ring and subscriber table come up empty, config at defaults.
// Stall: the response register holds while m_tready is low; the next request
// may be accepted and processed meanwhile, but it waits in its final step
// until the register is free.
module multi_reader_broadcast_ring (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mrbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrbr_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// caller[15:0], now_ms[47:16], payload_in[111:48], payload_len[115:112],
	// read_limit[119:116]
	input  logic [mrbr_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// payload_out[63:0], entry_len[67:64], occupancy[72:68], zero above
	output logic [mrbr_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [2:0]                      m_tuser
);
	import mrbr_pkg::*;

	cmd_t  cmd;
	stat_t st;

	mrbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mrbr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.st        (st)
	);

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		st.fill <= st.depth)
		else $error("ring fill count above depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while one is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= 3'd5))
		else $error("undefined status code on response");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[63:0] & ~byte_mask(m_tdata[67:64])) == '0))
		else $error("response payload bytes beyond entry length");

endmodule

// ===== verif/multi_reader_broadcast_ring_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_reader_broadcast_ring: a queue-fed driver, a clocked
// monitor and a behavioral predictor of the ring and subscriber table.
// Depends on mrbr_pkg and the block's RTL.
module multi_reader_broadcast_ring_test;
	import mrbr_pkg::*;

	typedef struct {
		op_t         op;
		logic [15:0] caller;
		logic [31:0] now;
		logic [63:0] data;
		logic [3:0]  len;
		logic [3:0]  lim;
	} request_t;

	typedef struct {
		status_t     status;
		logic [63:0] payload;
		logic [3:0]  elen;
		logic [4:0]  occ;
	} response_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0] m_tuser;

	multi_reader_broadcast_ring DUT (.*);

	always #2 clk = ~clk;

	// predictor state
	int unsigned depth_cfg, size_cfg, sublim_cfg, consume_cfg;
	logic [31:0] age_cfg;
	logic [63:0] r_pay [ENTRY_SLOTS];
	logic [3:0]  r_len [ENTRY_SLOTS];
	logic [31:0] r_stamp [ENTRY_SLOTS];
	int unsigned r_reads [ENTRY_SLOTS];
	bit          r_valid [ENTRY_SLOTS];
	logic [31:0] r_mask [ENTRY_SLOTS];
	int unsigned wpos, tail, fill;
	logic [15:0] sub_id [SUB_SLOTS];
	bit          sub_on [SUB_SLOTS];

	request_t  pending_reqs[$];
	response_t expected_resp[$];
	int errors = 0;
	bit tail_phase = 0;
	bit hold_long = 0;
	bit sender_pause = 0;

	function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [63:0] keep_bytes(int unsigned n);
		return n >= 8 ? '1 : ((64'd1 << (n * 8)) - 64'd1);
	endfunction

	function automatic int unsigned advance(int unsigned p);
		return (p + 1 >= depth_cfg) ? 0 : p + 1;
	endfunction

	function automatic void clear_ring();
		for (int i = 0; i < ENTRY_SLOTS; i++) begin
			r_reads[i] = 0; r_valid[i] = 0; r_mask[i] = 0;
		end
		wpos = 0; tail = 0; fill = 0;
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, logic [31:0] v);
		case (idx)
			REG_RING_DEPTH: begin
				depth_cfg = clamp(v[4:0], 1, ENTRY_SLOTS);
				clear_ring();
			end
			REG_SIZE_LIMIT: size_cfg = clamp(v[3:0], 1, 8);
			REG_SUB_LIMIT: sublim_cfg = clamp(v[5:0], 1, SUB_SLOTS);
			REG_AGE_LIMIT: age_cfg = v;
			REG_READS_CONSUME: consume_cfg = v[5:0];
			default: ;
		endcase
	endfunction

	function automatic int find_sub(logic [15:0] who);
		for (int i = 0; i < sublim_cfg; i++)
			if (sub_on[i] && sub_id[i] == who) return i;
		return -1;
	endfunction

	function automatic void age_out(logic [31:0] now);
		logic [31:0] age;
		if (age_cfg == 0) return;
		while (fill > 0) begin
			if (!r_valid[tail]) break;
			age = now - r_stamp[tail];
			if (age < age_cfg) break;
			r_valid[tail] = 0;
			tail = advance(tail);
			fill--;
		end
	endfunction

	function automatic response_t ring_predict(request_t rq);
		response_t rs;
		int s;
		int unsigned p, n;
		bit found;
		rs = '{ST_OK, 64'd0, 4'd0, 5'd0};
		s = find_sub(rq.caller);
		case (rq.op)
			OP_PUBLISH: begin
				if (rq.len == 0 || rq.len > size_cfg) rs.status = ST_BAD_LEN;
				else begin
					age_out(rq.now);
					if (fill >= depth_cfg) begin
						r_valid[tail] = 0; tail = advance(tail); fill--;
					end
					r_pay[wpos] = rq.data & keep_bytes(rq.len);
					r_len[wpos] = rq.len;
					r_stamp[wpos] = rq.now;
					r_reads[wpos] = 0; r_mask[wpos] = 0; r_valid[wpos] = 1;
					wpos = advance(wpos);
					fill++;
				end
			end
			OP_READ: begin
				if (s < 0) rs.status = ST_NOT_SUB;
				else begin
					age_out(rq.now);
					p = tail; found = 0;
					for (int i = 0; i < fill; i++) begin
						if (r_valid[p] && !r_mask[p][s]) begin
							found = 1; break;
						end
						p = advance(p);
					end
					if (!found) rs.status = ST_NO_DATA;
					else begin
						n = r_len[p] < rq.lim ? r_len[p] : rq.lim;
						rs.payload = r_pay[p] & keep_bytes(n);
						rs.elen = r_len[p];
						r_mask[p][s] = 1'b1;
						if (r_reads[p] < 63) r_reads[p]++;
						if (consume_cfg > 0 && r_reads[p] >= consume_cfg) begin
							r_valid[p] = 0;
							if (p == tail)
								while (fill > 0 && !r_valid[tail]) begin
									tail = advance(tail); fill--;
								end
						end
					end
				end
			end
			OP_SUBSCRIBE: begin
				if (s >= 0) rs.status = ST_ALREADY;
				else begin
					rs.status = ST_FULL;
					for (int i = 0; i < sublim_cfg; i++)
						if (!sub_on[i]) begin
							sub_id[i] = rq.caller; sub_on[i] = 1; rs.status = ST_OK;
							break;
						end
				end
			end
			default: begin
				if (s < 0) rs.status = ST_NOT_SUB;
				else sub_on[s] = 0;
			end
		endcase
		rs.occ = fill[4:0];
		return rs;
	endfunction

	// driver: offer the head of the queue, idle in random bursts
	int send_gap = 0;
	always @(posedge clk) begin
		request_t r;
		int gap;
		if (arst_n) begin
			gap = send_gap;
			if (s_tvalid && s_tready) begin
				expected_resp.push_back(ring_predict(pending_reqs.pop_front()));
				if (!tail_phase && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
			end else if (gap > 0) gap = gap - 1;
			if (tail_phase) gap = 0;
			send_gap <= gap;
			if (s_tvalid && !s_tready) begin
				// keep offering the same transaction
			end else if (pending_reqs.size() > 0 && !sender_pause && gap == 0) begin
				r = pending_reqs[0];
				s_tvalid <= 1;
				s_tuser <= r.op;
				s_tdata <= {r.lim, r.len, r.data, r.now, r.caller};
			end else s_tvalid <= 0;
		end
	end

	// monitor and receiver stalls
	int recv_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				response_t e;
				if (expected_resp.size() == 0) begin
					$error("response with nothing expected");
					errors++;
				end else begin
					e = expected_resp.pop_front();
					if (m_tuser !== e.status) begin
						$error("status exp %0d got %0d", e.status, m_tuser); errors++;
					end
					if (m_tdata[63:0] !== e.payload) begin
						$error("payload_out exp %h got %h", e.payload, m_tdata[63:0]);
						errors++;
					end
					if (m_tdata[67:64] !== e.elen) begin
						$error("entry_len exp %0d got %0d", e.elen, m_tdata[67:64]); errors++;
					end
					if (m_tdata[72:68] !== e.occ) begin
						$error("occupancy exp %0d got %0d", e.occ, m_tdata[72:68]); errors++;
					end
				end
			end
			if (hold_long) m_tready <= 0;
			else if (tail_phase) m_tready <= 1;
			else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= (recv_gap == 1);
			end else if ($urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(1, 10);
				m_tready <= 0;
			end else m_tready <= 1;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_tvalid || expected_resp.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		apply_reg(idx, v);
	endtask

	function automatic request_t make_req(op_t op, logic [15:0] who, logic [31:0] now,
			logic [63:0] d, logic [3:0] len, logic [3:0] lim);
		request_t r;
		r.op = op; r.caller = who; r.now = now; r.data = d; r.len = len; r.lim = lim;
		return r;
	endfunction

	logic [15:0] actors [6] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h00AA, 16'h7F00};
	logic [31:0] clock_ms = 0;

	task automatic random_phase(int count);
		int k;
		request_t r;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			clock_ms += $urandom_range(0, 40);
			r = make_req(OP_READ, actors[$urandom_range(0, 5)], clock_ms,
				{$urandom, $urandom}, 4'($urandom_range(1, 8)), 4'($urandom_range(0, 15)));
			if (k < 40) r.op = OP_PUBLISH;
			else if (k < 75) r.op = OP_READ;
			else if (k < 88) r.op = OP_SUBSCRIBE;
			else r.op = OP_UNSUBSCRIBE;
			if ($urandom_range(0, 9) == 0) r.len = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 19) == 0) r.caller = 16'($urandom);
			if ($urandom_range(0, 29) == 0) r.now = $urandom;
			pending_reqs.push_back(r);
		end
	endtask

	initial begin
		depth_cfg = 16; size_cfg = 8; sublim_cfg = 32; age_cfg = 0; consume_cfg = 0;
		clear_ring();
		for (int i = 0; i < SUB_SLOTS; i++) begin
			sub_id[i] = 0; sub_on[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: bad lengths, reads without subscription, all ops, extremes
		pending_reqs.push_back(make_req(OP_PUBLISH, 16'h0001, 0, '1, 4'd0, 4'd0));
		pending_reqs.push_back(make_req(OP_PUBLISH, 16'h0001, 0, '1, 4'd9, 4'd0));
		pending_reqs.push_back(make_req(OP_PUBLISH, 16'h0001, 0, '1, 4'd15, 4'd0));
		pending_reqs.push_back(make_req(OP_READ, 16'hFFFF, 0, '0, 4'd0, 4'd8));
		pending_reqs.push_back(make_req(OP_UNSUBSCRIBE, 16'hFFFF, 0, '0, 4'd0, 4'd0));
		pending_reqs.push_back(make_req(OP_SUBSCRIBE, 16'hFFFF, 0, '0, 4'd0, 4'd0));
		pending_reqs.push_back(make_req(OP_SUBSCRIBE, 16'hFFFF, 0, '0, 4'd0, 4'd0));
		pending_reqs.push_back(make_req(OP_SUBSCRIBE, 16'h0000, 0, '0, 4'd0, 4'd0));
		pending_reqs.push_back(make_req(OP_READ, 16'hFFFF, 0, '0, 4'd0, 4'd8));
		pending_reqs.push_back(make_req(OP_PUBLISH, 16'h0000, 32'hFFFFFFFF, '1, 4'd8, 4'd0));
		pending_reqs.push_back(make_req(OP_PUBLISH, 16'h0000, 5, 64'h0123456789ABCDEF, 4'd3,
			4'd0));
		pending_reqs.push_back(make_req(OP_READ, 16'hFFFF, 6, '0, 4'd0, 4'd15));
		pending_reqs.push_back(make_req(OP_READ, 16'hFFFF, 6, '0, 4'd0, 4'd2));
		pending_reqs.push_back(make_req(OP_READ, 16'h0000, 6, '0, 4'd0, 4'd0));
		pending_reqs.push_back(make_req(OP_READ, 16'hFFFF, 6, '0, 4'd0, 4'd8));
		pending_reqs.push_back(make_req(OP_UNSUBSCRIBE, 16'hFFFF, 7, '0, 4'd0, 4'd0));
		pending_reqs.push_back(make_req(OP_SUBSCRIBE, 16'h5555, 7, '0, 4'd0, 4'd0));
		pending_reqs.push_back(make_req(OP_READ, 16'h5555, 7, '0, 4'd0, 4'd8));
		wait_drained();

		// small ring, tight limits, consume after one read, short lifetime
		write_reg(REG_RING_DEPTH, 1);
		write_reg(REG_SIZE_LIMIT, 1);
		write_reg(REG_SUB_LIMIT, 1);
		write_reg(REG_AGE_LIMIT, 1);
		write_reg(REG_READS_CONSUME, 1);
		random_phase(60);
		wait_drained();

		// mid settings; long receiver hold while the sender keeps offering
		write_reg(REG_RING_DEPTH, 4);
		write_reg(REG_SIZE_LIMIT, 8);
		write_reg(REG_SUB_LIMIT, 3);
		write_reg(REG_AGE_LIMIT, 60);
		write_reg(REG_READS_CONSUME, 2);
		hold_long <= 1;
		random_phase(100);
		repeat (3000) @(posedge clk);
		hold_long <= 0;
		wait_drained();

		// sender pauses with items pending until every response is in
		random_phase(40);
		repeat (400) @(posedge clk);
		sender_pause <= 1;
		@(posedge clk);
		while (s_tvalid || expected_resp.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		sender_pause <= 0;
		wait_drained();

		// maximum settings, consume setting beyond the table, wrapping clock
		write_reg(REG_RING_DEPTH, 31);
		write_reg(REG_SIZE_LIMIT, 15);
		write_reg(REG_SUB_LIMIT, 63);
		write_reg(REG_AGE_LIMIT, 32'hFFFFFFFF);
		write_reg(REG_READS_CONSUME, 63);
		clock_ms = 32'hFFFFFF00;
		random_phase(120);
		wait_drained();

		write_reg(REG_RING_DEPTH, 8);
		write_reg(REG_SIZE_LIMIT, 5);
		write_reg(REG_AGE_LIMIT, 0);
		write_reg(REG_READS_CONSUME, 3);
		random_phase(100);
		repeat (400) @(posedge clk);
		tail_phase <= 1;
		wait_drained();

		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#4ms;
		$display("FAIL");
		$finish;
	end
endmodule
